// ===== rtl/core/kfb_pkg.sv =====
// Shared types and constants for the KWP2000 request frame builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kfb_pkg;

  // Frame format constants.
  localparam logic [7:0] FMT_BASE            = 8'h80;
  localparam logic [6:0] SHORT_LIMIT         = 7'd63;
  localparam int         DEFAULT_MAX_PAYLOAD = 127;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  // Input item kinds.
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DATA  = 1'b1
  } func_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_TARGET = 1'b0,
    CFG_SOURCE = 1'b1
  } cfg_idx_t;

  // Position within the byte sequence produced by one item.
  typedef enum logic [2:0] {
    STEP_FIRST  = 3'd0,
    STEP_SECOND = 3'd1,
    STEP_THIRD  = 3'd2,
    STEP_FOURTH = 3'd3,
    STEP_FIFTH  = 3'd4
  } step_t;

  // One input item as held in the input register.
  typedef struct packed {
    func_t             func;
    logic [BYTE_W-1:0] service_byte;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] payload_byte;
  } item_t;

  // Addresses taken from the configuration registers.
  typedef struct packed {
    logic [BYTE_W-1:0] target_address;
    logic [BYTE_W-1:0] source_address;
  } addr_cfg_t;

endpackage

// ===== rtl/core/kfb_in_stage.sv =====
// Input register of the frame builder: holds one item until the sequencer releases it.
// Depends on kfb_pkg.
`timescale 1ns / 1ps

module kfb_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kfb_pkg::item_t in_item,
  input  logic          release_item,
  output logic          hold_valid,
  output kfb_pkg::item_t hold_item
);
  import kfb_pkg::*;

  logic  hold_valid_r;
  logic  hold_valid_nxt;
  item_t hold_item_r;
  logic  load;

  // A new item may enter when the register is empty or is emptied this cycle.
  assign in_ready = !hold_valid_r || release_item;
  assign load     = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (load) begin
      hold_valid_nxt = 1'b1;
    end else if (release_item) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      hold_item_r <= in_item;
    end
  end

  assign hold_valid = hold_valid_r;
  assign hold_item  = hold_item_r;

endmodule

// ===== rtl/core/kfb_sequencer.sv =====
// Frame sequencer: walks the bytes one held item produces, keeps the frame state
// and drives the result register. Depends on kfb_pkg.
`timescale 1ns / 1ps

module kfb_sequencer #(
  parameter int MAX_PAYLOAD = kfb_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       hold_valid,
  input  kfb_pkg::item_t             hold_item,
  input  kfb_pkg::addr_cfg_t         addr_cfg,
  output logic                       release_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kfb_pkg::BYTE_W-1:0] out_frame_byte,
  output logic                       out_frame_end
);
  import kfb_pkg::*;

  localparam logic [BYTE_W-1:0] MaxPl = BYTE_W'(MAX_PAYLOAD);

  // Frame state.
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              open_r, open_nxt;
  step_t             step_r, step_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;

  // Decode of the current step.
  logic              is_start;
  logic              is_long;
  logic              drop;
  logic              out_free;
  logic              emit;
  logic              last_step;
  logic              is_sum;
  logic [BYTE_W-1:0] cur_byte;

  assign is_start = hold_item.func == FUNC_START;
  assign is_long  = hold_item.payload_length >= SHORT_LIMIT;
  assign out_free = !out_valid_r || out_ready;

  // An oversized start or a stray data item produces nothing. The check on a data
  // item applies to its payload byte only; its checksum step follows regardless.
  always_comb begin
    if (is_start) begin
      drop = {1'b0, hold_item.payload_length} > MaxPl;
    end else begin
      drop = (step_r == STEP_FIRST) && (!open_r || (left_r == '0));
    end
  end

  assign emit         = hold_valid && !drop && out_free;
  assign release_item = hold_valid && (drop || (emit && last_step));

  // Select the byte for the current step.
  always_comb begin
    cur_byte  = sum_r;
    last_step = 1'b1;
    is_sum    = 1'b0;
    if (is_start) begin
      unique case (step_r)
        STEP_FIRST: begin
          cur_byte  = is_long ? FMT_BASE
                              : FMT_BASE + BYTE_W'(hold_item.payload_length) + 8'd1;
          last_step = 1'b0;
        end
        STEP_SECOND: begin
          cur_byte  = addr_cfg.target_address;
          last_step = 1'b0;
        end
        STEP_THIRD: begin
          cur_byte  = addr_cfg.source_address;
          last_step = 1'b0;
        end
        STEP_FOURTH: begin
          cur_byte  = is_long ? BYTE_W'(hold_item.payload_length) + 8'd1
                              : hold_item.service_byte;
          last_step = !is_long && (hold_item.payload_length != '0);
        end
        default: begin
          // Long form ends on the service byte, an empty short frame on its sum.
          cur_byte = is_long ? hold_item.service_byte : sum_r;
          is_sum   = !is_long;
        end
      endcase
    end else begin
      if (step_r == STEP_FIRST) begin
        cur_byte  = hold_item.payload_byte;
        last_step = left_r != LEN_W'(1);
      end else begin
        cur_byte = sum_r;
        is_sum   = 1'b1;
      end
    end
  end

  // Next frame state and step.
  always_comb begin
    sum_nxt  = sum_r;
    left_nxt = left_r;
    open_nxt = open_r;
    step_nxt = step_r;
    if (emit) begin
      step_nxt = last_step ? STEP_FIRST : step_t'(step_r + 3'd1);
      if (is_sum) begin
        sum_nxt  = '0;
        left_nxt = '0;
        open_nxt = 1'b0;
      end else if (is_start && step_r == STEP_FIRST) begin
        sum_nxt  = cur_byte;
        left_nxt = hold_item.payload_length;
        open_nxt = 1'b1;
      end else begin
        sum_nxt = sum_r + cur_byte;
        if (!is_start) begin
          left_nxt = left_r - LEN_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      left_r      <= '0;
      open_r      <= 1'b0;
      step_r      <= STEP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      left_r      <= left_nxt;
      open_r      <= open_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= cur_byte;
      out_end_r  <= is_sum;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

endmodule

// ===== rtl/core/kwp2000_frame_builder.sv =====
// KWP2000 request frame builder: one byte per cycle after an input register,
// while the result channel is not stalled. A data item gives its payload byte (the
// last one also adds the sum); a start gives its header bytes one by one through the
// shared result register.
// Reset (synchronous, rst_n low): no frame open, addresses 0x10 / 0xF1, outputs empty.
`timescale 1ns / 1ps

module kwp2000_frame_builder #(
  parameter int MAX_PAYLOAD = kfb_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration write port.
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [kfb_pkg::BYTE_W-1:0] cfg_data,
  // Input channel.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [kfb_pkg::BYTE_W-1:0] in_service_byte,
  input  logic [kfb_pkg::LEN_W-1:0]  in_payload_length,
  input  logic [kfb_pkg::BYTE_W-1:0] in_payload_byte,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kfb_pkg::BYTE_W-1:0] out_frame_byte,
  output logic                       out_frame_end
);
  import kfb_pkg::*;

  addr_cfg_t cfg_r;
  item_t     in_item;
  item_t     hold_item;
  logic      hold_valid;
  logic      release_item;

  // Address registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_address <= 8'h10;
      cfg_r.source_address <= 8'hF1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TARGET: cfg_r.target_address <= cfg_data;
        CFG_SOURCE: cfg_r.source_address <= cfg_data;
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_item.func           = func_t'(in_func);
  assign in_item.service_byte   = in_service_byte;
  assign in_item.payload_length = in_payload_length;
  assign in_item.payload_byte   = in_payload_byte;

  kfb_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .release_item (release_item),
    .hold_valid   (hold_valid),
    .hold_item    (hold_item)
  );

  kfb_sequencer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_sequencer (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold_valid     (hold_valid),
    .hold_item      (hold_item),
    .addr_cfg       (cfg_r),
    .release_item   (release_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

endmodule

// ===== rtl/core/kfb_checker.sv =====
// Port-level checks for the frame builder and the bind that attaches them.
// Depends on kfb_pkg and kwp2000_frame_builder.
`timescale 1ns / 1ps

module kfb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [kfb_pkg::BYTE_W-1:0] out_frame_byte,
  input logic                       out_frame_end
);
  import kfb_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input register is free right after reset.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // A stalled result holds its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
      && $stable(out_frame_end))
    else $error("stalled result changed");

  // A checksum is always followed by a header byte, never another checksum.
  a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_end |=> !(out_valid && out_frame_end))
    else $error("two frame ends in a row");

endmodule

bind kwp2000_frame_builder kfb_checker u_kfb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_byte (out_frame_byte),
  .out_frame_end  (out_frame_end)
);

// ===== verif/kwp2000_frame_builder_tb.sv =====
// Self-checking testbench for the KWP2000 request frame builder.
// Depends on kfb_pkg and kwp2000_frame_builder; a built-in frame predictor
// checks every result byte under random idling, stalls and address settings.
`timescale 1ns / 1ps

module kwp2000_frame_builder_tb;
  import kfb_pkg::*;

  localparam int MAX_PAYLOAD  = DEFAULT_MAX_PAYLOAD;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 16;

  // One expected result byte.
  typedef struct packed {
    logic [BYTE_W-1:0] fbyte;
    logic              fend;
  } frame_out_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  cfg_idx_t          cfg_index = CFG_TARGET;
  logic [BYTE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  func_t             in_func = FUNC_START;
  logic [BYTE_W-1:0] in_service_byte = '0;
  logic [LEN_W-1:0]  in_payload_length = '0;
  logic [BYTE_W-1:0] in_payload_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_frame_byte;
  logic              out_frame_end;

  // Stimulus and expectation stores.
  item_t      pending_q[$];
  frame_out_t frame_byte_q[$];
  item_t      on_bus;

  // Predictor copy of the block's registers and frame state.
  logic [BYTE_W-1:0] tgt_addr = 8'h10;
  logic [BYTE_W-1:0] src_addr = 8'hF1;
  logic [BYTE_W-1:0] sum_acc = '0;
  logic [LEN_W-1:0]  left_cnt = '0;
  logic              open_flag = 1'b0;

  // Run control and bookkeeping.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   cycle_cnt = 0;
  int   err_cnt = 0;
  int   items_accepted = 0;
  int   bytes_checked = 0;
  int   frames_closed = 0;
  int   items_queued = 0;

  kwp2000_frame_builder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_service_byte   (in_service_byte),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_byte    (out_frame_byte),
    .out_frame_end     (out_frame_end)
  );

  always #2 clk = ~clk;

  // Append one frame byte to the expectations; the checksum itself is not summed.
  function automatic void emit_byte(input logic [BYTE_W-1:0] b, input logic last);
    frame_byte_q.push_back('{fbyte: b, fend: last});
    if (!last) sum_acc = sum_acc + b;
  endfunction

  // Close the frame with its checksum byte.
  function automatic void emit_checksum();
    emit_byte(sum_acc, 1'b1);
    open_flag = 1'b0;
    left_cnt  = '0;
    sum_acc   = '0;
  endfunction

  // Work out the frame bytes that one accepted item produces.
  function automatic void predict_frame_bytes(input item_t it);
    if (it.func == FUNC_START) begin
      if (int'(it.payload_length) > MAX_PAYLOAD) return;
      sum_acc = '0;
      if (it.payload_length < SHORT_LIMIT) begin
        emit_byte(FMT_BASE + 8'd1 + {1'b0, it.payload_length}, 1'b0);
        emit_byte(tgt_addr, 1'b0);
        emit_byte(src_addr, 1'b0);
      end else begin
        emit_byte(FMT_BASE, 1'b0);
        emit_byte(tgt_addr, 1'b0);
        emit_byte(src_addr, 1'b0);
        emit_byte({1'b0, it.payload_length} + 8'd1, 1'b0);
      end
      emit_byte(it.service_byte, 1'b0);
      left_cnt  = it.payload_length;
      open_flag = 1'b1;
      if (it.payload_length == '0) emit_checksum();
    end else if (open_flag && left_cnt != '0) begin
      emit_byte(it.payload_byte, 1'b0);
      left_cnt = left_cnt - 1'b1;
      if (left_cnt == '0) emit_checksum();
    end
  endfunction

  // Queue a start item; the unused payload byte is random.
  function automatic void push_start(input logic [BYTE_W-1:0] svc, input logic [LEN_W-1:0] n);
    item_t it;
    it.func           = FUNC_START;
    it.service_byte   = svc;
    it.payload_length = n;
    it.payload_byte   = BYTE_W'($urandom);
    pending_q.push_back(it);
    items_queued++;
  endfunction

  // Queue a data item; the unused start fields are random.
  function automatic void push_data(input logic [BYTE_W-1:0] b);
    item_t it;
    it.func           = FUNC_DATA;
    it.service_byte   = BYTE_W'($urandom);
    it.payload_length = LEN_W'($urandom);
    it.payload_byte   = b;
    pending_q.push_back(it);
    items_queued++;
  endfunction

  // Start a frame of n bytes and send the first k of them.
  function automatic void push_frame(input logic [LEN_W-1:0] n, input int k);
    push_start(BYTE_W'($urandom), n);
    for (int i = 0; i < k; i++) push_data(BYTE_W'($urandom));
  endfunction

  // Payload lengths lean short so that many frames fit into a phase.
  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return LEN_W'($urandom_range(0, 6));
    if (r < 92) return LEN_W'($urandom_range(7, 30));
    if (r < 97) return LEN_W'($urandom_range(63, 66));
    return LEN_W'($urandom_range(124, 127));
  endfunction

  // Mostly complete frames, some abandoned by a new start, some stray data bytes.
  function automatic void push_random_traffic(input int budget);
    int stop_at;
    int r;
    logic [LEN_W-1:0] n;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      r = $urandom_range(0, 99);
      n = pick_len();
      if (r < 8) begin
        push_data(BYTE_W'($urandom));
      end else if (r < 20 && n != '0) begin
        push_frame(n, $urandom_range(0, int'(n) - 1));
        push_frame(pick_len(), 0);
        n = pending_q[$].payload_length;
        for (int i = 0; i < int'(n); i++) push_data(BYTE_W'($urandom));
      end else begin
        push_frame(n, int'(n));
      end
    end
  endfunction

  // Wait until every item is taken and every byte has come, then let the block settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || frame_byte_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both address registers while the block is idle.
  task automatic write_addrs(input logic [BYTE_W-1:0] tgt, input logic [BYTE_W-1:0] src);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET;
    cfg_data  <= tgt;
    tgt_addr = tgt;
    @(posedge clk);
    cfg_index <= CFG_SOURCE;
    cfg_data  <= src;
    src_addr = src;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Driver: offers the head of the pending queue and predicts on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_frame_bytes(on_bus);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_q.pop_front();
          in_valid          <= 1'b1;
          in_func           <= on_bus.func;
          in_service_byte   <= on_bus.service_byte;
          in_payload_length <= on_bus.payload_length;
          in_payload_byte   <= on_bus.payload_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down in its own process.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compares each accepted result byte with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_byte_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, got byte %02h end %0b",
                   $time, out_frame_byte, out_frame_end);
          err_cnt++;
        end else begin
          if (out_frame_byte !== frame_byte_q[0].fbyte) begin
            $display("%0t: frame_byte mismatch: expected %02h, got %02h",
                     $time, frame_byte_q[0].fbyte, out_frame_byte);
            err_cnt++;
          end
          if (out_frame_end !== frame_byte_q[0].fend) begin
            $display("%0t: frame_end mismatch: expected %0b, got %0b",
                     $time, frame_byte_q[0].fend, out_frame_end);
            err_cnt++;
          end
          if (frame_byte_q[0].fend) frames_closed++;
          void'(frame_byte_q.pop_front());
          bytes_checked++;
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_cnt, frame_byte_q.size());
      $display("FAIL kwp2000_frame_builder");
      $finish;
    end
  end

  // Sequence of phases.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset addresses.
    push_data(8'h00);              // stray data byte straight after reset
    push_start(8'h00, 7'd0);       // empty payload
    push_start(8'hFF, 7'd0);
    push_start(8'h3E, 7'd2);
    push_data(8'h00);
    push_data(8'hFF);
    push_data(8'hFF);              // stray data byte after a closed frame
    push_start(8'h21, 7'd62);      // largest short form, abandoned
    push_data(8'h5A);
    push_start(8'h1A, 7'd63);      // smallest long form, abandoned by a new start
    push_data(8'h01);
    push_data(8'h02);
    push_start(8'h81, 7'd127);     // largest long form, abandoned at once
    push_start(8'h10, 7'd1);
    push_data(8'hAA);
    wait_idle();

    // No idling, extreme addresses, one long receiver hold-off.
    write_addrs(8'h00, 8'hFF);
    set_idling(0, 0);
    push_random_traffic(PHASE_ITEMS);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    // Leave a frame open across the next address change.
    push_frame(7'd3, 1);
    wait_idle();

    // Sender idling; the open frame finishes under the new addresses.
    write_addrs(8'hFF, 8'h00);
    set_idling(45, 0);
    push_data(BYTE_W'($urandom));
    push_data(BYTE_W'($urandom));
    push_frame(7'd127, 127);
    push_random_traffic(PHASE_ITEMS);
    wait_idle();

    // Receiver stalling, random addresses.
    write_addrs(BYTE_W'($urandom), BYTE_W'($urandom));
    set_idling(0, 45);
    push_random_traffic(PHASE_ITEMS);
    wait_idle();

    // Both sides idling.
    write_addrs(BYTE_W'($urandom), BYTE_W'($urandom));
    set_idling(17, 17);
    push_random_traffic(PHASE_ITEMS);
    wait_idle();

    $display("Covered %0d input items, %0d frame bytes checked, %0d frames closed,",
             items_accepted, bytes_checked, frames_closed);
    $display("over short and long forms, stray and abandoned frames and five address settings.");
    if (err_cnt == 0) begin
      $display("PASS kwp2000_frame_builder");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL kwp2000_frame_builder");
    end
    $finish;
  end

endmodule
